// ===== src/bb3_pkg.sv =====
package bb3_pkg;

   // line store geometry
   localparam int MAX_WIDTH = 1024;
   localparam int COL_W     = $clog2(MAX_WIDTH);

   // register and field widths
   localparam int WCFG_W = 11;
   localparam int HCFG_W = 12;
   localparam int CSR_W  = 12;
   localparam int ROW_W  = 12;
   localparam int POS_W  = 22;
   localparam int PIX_W  = 24;
   localparam int CH_W   = 8;
   localparam int SUM_W  = 12;
   localparam int CNT_W  = 4;

   // register indexes
   localparam logic [0:0] CSR_WIDTH  = 1'b0;
   localparam logic [0:0] CSR_HEIGHT = 1'b1;

   // request operations
   localparam logic [0:0] OP_PIXEL = 1'b0;
   localparam logic [0:0] OP_DRAIN = 1'b1;

   // post-shift divide codes: 2*count = 2^k, 3*2^k or 9*2
   localparam logic [1:0] DIV_NONE = 2'd0;
   localparam logic [1:0] DIV_3    = 2'd1;
   localparam logic [1:0] DIV_9    = 2'd2;

   // reciprocal multipliers, exact for the operand ranges that occur
   localparam int MUL_W = 12;
   localparam logic [MUL_W-1:0] MUL3 = 12'd2731;
   localparam int SH3 = 13;
   localparam logic [MUL_W-1:0] MUL9 = 12'd1821;
   localparam int SH9 = 14;

endpackage

// ===== src/bb3_ram.sv =====
module bb3_ram #(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 24,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic             re,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // read-first: a read and a write at the same address return the old word
   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== src/bb3_div.sv =====
module bb3_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [bb3_pkg::POS_W-1:0]  dividend,
   input  logic [bb3_pkg::WCFG_W-1:0] divisor,
   output logic                       done,
   output logic [bb3_pkg::POS_W-1:0]  quotient,
   output logic [bb3_pkg::WCFG_W-1:0] remainder
);

   localparam int CNT_BITS = $clog2(bb3_pkg::POS_W + 1);

   logic                       run_ff, run_in;
   logic [CNT_BITS-1:0]        cnt_ff, cnt_in;
   logic [bb3_pkg::POS_W-1:0]  quo_ff, quo_in;
   logic [bb3_pkg::WCFG_W-1:0] rem_ff, rem_in;
   logic [bb3_pkg::WCFG_W:0]   shifted;
   logic [bb3_pkg::WCFG_W:0]   diff;
   logic                       ge;

   // one quotient bit per cycle, restoring
   always_comb begin
      shifted = {rem_ff, quo_ff[bb3_pkg::POS_W-1]};
      ge      = shifted >= {1'b0, divisor};
      diff    = shifted - {1'b0, divisor};
      run_in  = run_ff;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      done    = 1'b0;
      if (start) begin
         run_in = 1'b1;
         cnt_in = CNT_BITS'(bb3_pkg::POS_W);
         quo_in = dividend;
         rem_in = '0;
      end else if (run_ff) begin
         if (cnt_ff == '0) begin
            done   = 1'b1;
            run_in = 1'b0;
         end else begin
            cnt_in = cnt_ff - 1'b1;
            quo_in = {quo_ff[bb3_pkg::POS_W-2:0], ge};
            rem_in = ge ? diff[bb3_pkg::WCFG_W-1:0] : shifted[bb3_pkg::WCFG_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         run_ff <= run_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

// ===== src/box_blur_3x3_rgb_unit.sv =====
// channel   direction  handshake                  payload
// req       in         req_valid / req_stall      req_operation, req_red, req_green, req_blue
// rsp       out        rsp_valid / rsp_stall      rsp_out_red, rsp_out_green, rsp_out_blue,
//                                                 rsp_frame_end
// csr       in         csr_valid / csr_ready      csr_index, csr_wdata
//
// one request per cycle while req_stall is low; a result is registered at each step after its request
// (line store read, window sum, pre-shift, reciprocal multiply into the output register)
// the two line stores are read at the request's column and one of them written in the same cycle
// after reset and after every csr write the output row/column are rebuilt by a 22-step
// divider: req_stall stays high until the divider is done
// a stalled rsp stops the pipeline stage by stage; empty stages still take requests

module box_blur_3x3_rgb_unit (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [0:0]                 req_operation,
   input  logic [7:0]                 req_red,
   input  logic [7:0]                 req_green,
   input  logic [7:0]                 req_blue,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [7:0]                 rsp_out_red,
   output logic [7:0]                 rsp_out_green,
   output logic [7:0]                 rsp_out_blue,
   output logic                       rsp_frame_end,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [0:0]                 csr_index,
   input  logic [bb3_pkg::CSR_W-1:0]  csr_wdata
);

   localparam int COL_W  = bb3_pkg::COL_W;
   localparam int POS_W  = bb3_pkg::POS_W;
   localparam int PIX_W  = bb3_pkg::PIX_W;
   localparam int CH_W   = bb3_pkg::CH_W;
   localparam int SUM_W  = bb3_pkg::SUM_W;
   localparam int CNT_W  = bb3_pkg::CNT_W;
   localparam int WCFG_W = bb3_pkg::WCFG_W;
   localparam int HCFG_W = bb3_pkg::HCFG_W;
   localparam int ROW_W  = bb3_pkg::ROW_W;
   localparam int MUL_W  = bb3_pkg::MUL_W;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_START = 2'd1;
   localparam logic [1:0] ST_RUN   = 2'd2;

   typedef struct packed {
      logic       bank;
      logic       emit;
      logic [2:0] ok_col;
      logic [2:0] ok_row;
      logic       last;
   } ctl_type;

   // configuration and position setup
   logic [WCFG_W-1:0] width_ff, width_in;
   logic [HCFG_W-1:0] height_ff, height_in;
   logic [1:0]        state_ff, state_in;
   logic [POS_W-1:0]  total_ff;
   logic [WCFG_W-1:0] w_eff, w_m1;
   logic [HCFG_W-1:0] h_eff, h_m1;
   logic              div_start, div_done;
   logic [POS_W-1:0]  div_quo;
   logic [WCFG_W-1:0] div_rem;

   // input and output position counters
   logic [COL_W-1:0]  in_column_ff, in_column_in;
   logic [ROW_W-1:0]  in_row_ff, in_row_in;
   logic [POS_W-1:0]  q_ff, q_in;
   logic [POS_W-1:0]  orow_ff, orow_in;
   logic [COL_W-1:0]  ocol_ff, ocol_in;

   // request stage
   logic              accept;
   logic [COL_W-1:0]  col;
   logic [PIX_W-1:0]  pix;
   ctl_type           ctl0;
   logic              col_wrap, ocol_wrap;

   // window stage
   logic              v1_ff, v1_in;
   ctl_type           s1_ctl_ff;
   logic [PIX_W-1:0]  s1_pix_ff;
   logic [PIX_W-1:0]  rd0, rd1, top, mid;
   logic [PIX_W-1:0]  win_ff [6];
   logic [PIX_W-1:0]  win [9];
   logic [8:0]        mask;
   logic [SUM_W-1:0]  sum [3];
   logic [CNT_W-1:0]  count;
   logic              s1_go, s1_free;

   // sum stage
   logic              v2_ff, v2_in;
   logic [SUM_W-1:0]  s2_sum_ff [3];
   logic [CNT_W-1:0]  s2_count_ff;
   logic              s2_last_ff;
   logic              s2_free;
   logic [SUM_W:0]    x [3];
   logic [1:0]        pre_sh;
   logic [1:0]        div_code;

   // scale stage
   logic              v3_ff, v3_in;
   logic [SUM_W-1:0]  s3_y_ff [3];
   logic [1:0]        s3_code_ff;
   logic              s3_last_ff;
   logic              s3_free;
   logic [MUL_W-1:0]  k;
   logic [SUM_W+MUL_W-1:0] prod [3];
   logic [CH_W-1:0]   res [3];

   // output register
   logic              vout_ff, vout_in;
   logic              out_free;
   logic [CH_W-1:0]   out_ch_ff [3];
   logic              out_last_ff;

   // ------------------------------------------------------------------ configuration

   always_comb begin
      w_eff = width_ff;
      if (width_ff == '0) begin
         w_eff = WCFG_W'(1);
      end else if (width_ff > WCFG_W'(bb3_pkg::MAX_WIDTH)) begin
         w_eff = WCFG_W'(bb3_pkg::MAX_WIDTH);
      end
      h_eff = (height_ff == '0) ? HCFG_W'(1) : height_ff;
      w_m1  = w_eff - 1'b1;
      h_m1  = h_eff - 1'b1;
   end

   assign csr_ready = (state_ff == ST_IDLE);

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            bb3_pkg::CSR_WIDTH:  width_in  = csr_wdata[WCFG_W-1:0];
            bb3_pkg::CSR_HEIGHT: height_in = csr_wdata[HCFG_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in  = state_ff;
      div_start = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (csr_valid) begin
               state_in = ST_START;
            end
         end
         ST_START: begin
            div_start = 1'b1;
            state_in  = ST_RUN;
         end
         ST_RUN: begin
            if (div_done) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_START;
      endcase
   end

   bb3_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (q_ff),
      .divisor   (w_eff),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WCFG_W'(640);
         height_ff <= HCFG_W'(480);
         state_ff  <= ST_START;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         state_ff  <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      total_ff <= POS_W'(w_eff * h_eff);
   end

   // ------------------------------------------------------------------ request stage

   assign out_free = !vout_ff || !rsp_stall;
   assign s3_free  = !v3_ff || out_free;
   assign s2_free  = !v2_ff || s3_free;
   assign s1_go    = v1_ff && (!s1_ctl_ff.emit || s2_free);
   assign s1_free  = !v1_ff || s1_go;

   assign req_stall = !(s1_free && (state_ff == ST_IDLE) && !csr_valid);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      col = ({1'b0, in_column_ff} >= w_eff) ? '0 : in_column_ff;
      pix = (req_operation == bb3_pkg::OP_DRAIN) ? '0 : {req_blue, req_green, req_red};
      col_wrap  = ({1'b0, col} == w_m1);
      ocol_wrap = ({1'b0, ocol_ff} >= w_m1);

      ctl0.bank   = in_row_ff[0];
      ctl0.emit   = (q_ff != '0) || (in_row_ff >= ROW_W'(2))
                    || ((in_row_ff == ROW_W'(1)) && (col != '0));
      ctl0.ok_col = {({1'b0, ocol_ff} < w_m1), 1'b1, (ocol_ff != '0)};
      ctl0.ok_row = {(orow_ff < POS_W'(h_m1)), 1'b1, (orow_ff != '0)};
      ctl0.last   = ctl0.emit && (({1'b0, q_ff} + 1'b1) >= {1'b0, total_ff});
   end

   always_comb begin
      in_column_in = in_column_ff;
      in_row_in    = in_row_ff;
      q_in         = q_ff;
      orow_in      = orow_ff;
      ocol_in      = ocol_ff;
      if (accept) begin
         if (ctl0.last) begin
            in_column_in = '0;
            in_row_in    = '0;
            q_in         = '0;
            orow_in      = '0;
            ocol_in      = '0;
         end else begin
            if (ctl0.emit) begin
               q_in = q_ff + 1'b1;
               if (ocol_wrap) begin
                  ocol_in = '0;
                  orow_in = orow_ff + 1'b1;
               end else begin
                  ocol_in = ocol_ff + 1'b1;
               end
            end
            if (col_wrap) begin
               in_column_in = '0;
               in_row_in    = in_row_ff + 1'b1;
            end else begin
               in_column_in = col + 1'b1;
            end
         end
      end else if ((state_ff == ST_RUN) && div_done) begin
         orow_in = div_quo;
         ocol_in = div_rem[COL_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_column_ff <= '0;
         in_row_ff    <= '0;
         q_ff         <= '0;
         orow_ff      <= '0;
         ocol_ff      <= '0;
      end else begin
         in_column_ff <= in_column_in;
         in_row_ff    <= in_row_in;
         q_ff         <= q_in;
         orow_ff      <= orow_in;
         ocol_ff      <= ocol_in;
      end
   end

   // bank of the current row holds the row two up; it is overwritten with the new pixel
   bb3_ram #(.DEPTH(bb3_pkg::MAX_WIDTH), .WIDTH(PIX_W)) u_bank0 (
      .clock (clock),
      .we    (accept && !ctl0.bank),
      .waddr (col),
      .wdata (pix),
      .re    (accept),
      .raddr (col),
      .rdata (rd0)
   );

   bb3_ram #(.DEPTH(bb3_pkg::MAX_WIDTH), .WIDTH(PIX_W)) u_bank1 (
      .clock (clock),
      .we    (accept && ctl0.bank),
      .waddr (col),
      .wdata (pix),
      .re    (accept),
      .raddr (col),
      .rdata (rd1)
   );

   // ------------------------------------------------------------------ window stage

   assign v1_in = s1_free ? accept : v1_ff;

   always_ff @(posedge clock) begin
      if (s1_free) begin
         s1_ctl_ff <= ctl0;
         s1_pix_ff <= pix;
      end
   end

   always_comb begin
      top = s1_ctl_ff.bank ? rd1 : rd0;
      mid = s1_ctl_ff.bank ? rd0 : rd1;
      for (int i = 0; i < 6; i++) begin
         win[i] = win_ff[i];
      end
      win[6] = top;
      win[7] = mid;
      win[8] = s1_pix_ff;
      for (int ci = 0; ci < 3; ci++) begin
         for (int ri = 0; ri < 3; ri++) begin
            mask[ci*3 + ri] = s1_ctl_ff.ok_col[ci] && s1_ctl_ff.ok_row[ri];
         end
      end
      count = '0;
      for (int i = 0; i < 9; i++) begin
         count = count + CNT_W'(mask[i]);
      end
      for (int ch = 0; ch < 3; ch++) begin
         sum[ch] = '0;
         for (int i = 0; i < 9; i++) begin
            if (mask[i]) begin
               sum[ch] = sum[ch] + SUM_W'(win[i][ch*CH_W +: CH_W]);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 6; i++) begin
            win_ff[i] <= '0;
         end
      end else if (s1_go) begin
         for (int i = 0; i < 6; i++) begin
            win_ff[i] <= s1_ctl_ff.last ? '0 : win[i + 3];
         end
      end
   end

   // ------------------------------------------------------------------ sum stage

   assign v2_in = s2_free ? (s1_go && s1_ctl_ff.emit) : v2_ff;

   always_ff @(posedge clock) begin
      if (s2_free) begin
         for (int ch = 0; ch < 3; ch++) begin
            s2_sum_ff[ch] <= sum[ch];
         end
         s2_count_ff <= count;
         s2_last_ff  <= s1_ctl_ff.last;
      end
   end

   // (2*sum + count) / (2*count): power-of-two part as a shift, then /3 or /9
   always_comb begin
      case (s2_count_ff)
         4'd1: begin
            pre_sh = 2'd1; div_code = bb3_pkg::DIV_NONE;
         end
         4'd2: begin
            pre_sh = 2'd2; div_code = bb3_pkg::DIV_NONE;
         end
         4'd3: begin
            pre_sh = 2'd1; div_code = bb3_pkg::DIV_3;
         end
         4'd4: begin
            pre_sh = 2'd3; div_code = bb3_pkg::DIV_NONE;
         end
         4'd6: begin
            pre_sh = 2'd2; div_code = bb3_pkg::DIV_3;
         end
         4'd9: begin
            pre_sh = 2'd1; div_code = bb3_pkg::DIV_9;
         end
         default: begin
            pre_sh = 2'd1; div_code = bb3_pkg::DIV_NONE;
         end
      endcase
      for (int ch = 0; ch < 3; ch++) begin
         x[ch] = {s2_sum_ff[ch], 1'b0} + (SUM_W+1)'(s2_count_ff);
      end
   end

   // ------------------------------------------------------------------ scale stage

   assign v3_in = s3_free ? v2_ff : v3_ff;

   always_ff @(posedge clock) begin
      if (s3_free) begin
         for (int ch = 0; ch < 3; ch++) begin
            s3_y_ff[ch] <= SUM_W'(x[ch] >> pre_sh);
         end
         s3_code_ff <= div_code;
         s3_last_ff <= s2_last_ff;
      end
   end

   always_comb begin
      k = (s3_code_ff == bb3_pkg::DIV_9) ? bb3_pkg::MUL9 : bb3_pkg::MUL3;
      for (int ch = 0; ch < 3; ch++) begin
         prod[ch] = (SUM_W+MUL_W)'(s3_y_ff[ch]) * (SUM_W+MUL_W)'(k);
         case (s3_code_ff)
            bb3_pkg::DIV_3: res[ch] = prod[ch][bb3_pkg::SH3 +: CH_W];
            bb3_pkg::DIV_9: res[ch] = prod[ch][bb3_pkg::SH9 +: CH_W];
            default:        res[ch] = s3_y_ff[ch][CH_W-1:0];
         endcase
      end
   end

   // ------------------------------------------------------------------ output register

   assign vout_in = out_free ? v3_ff : vout_ff;

   always_ff @(posedge clock) begin
      if (out_free) begin
         for (int ch = 0; ch < 3; ch++) begin
            out_ch_ff[ch] <= res[ch];
         end
         out_last_ff <= s3_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff   <= 1'b0;
         v2_ff   <= 1'b0;
         v3_ff   <= 1'b0;
         vout_ff <= 1'b0;
      end else begin
         v1_ff   <= v1_in;
         v2_ff   <= v2_in;
         v3_ff   <= v3_in;
         vout_ff <= vout_in;
      end
   end

   assign rsp_valid     = vout_ff;
   assign rsp_out_red   = out_ch_ff[0];
   assign rsp_out_green = out_ch_ff[1];
   assign rsp_out_blue  = out_ch_ff[2];
   assign rsp_frame_end = out_last_ff;

endmodule

// ===== dv/blur_checker.sv =====
`timescale 1ns / 100ps

module blur_checker (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_stall,
   input  logic [0:0]                req_operation,
   input  logic [7:0]                req_red,
   input  logic [7:0]                req_green,
   input  logic [7:0]                req_blue,
   input  logic                      rsp_valid,
   input  logic                      rsp_stall,
   input  logic [7:0]                rsp_out_red,
   input  logic [7:0]                rsp_out_green,
   input  logic [7:0]                rsp_out_blue,
   input  logic                      rsp_frame_end,
   input  logic                      csr_valid,
   input  logic                      csr_ready,
   input  logic [0:0]                csr_index,
   input  logic [bb3_pkg::CSR_W-1:0] csr_wdata,
   output int unsigned               fail_count,
   output int unsigned               expect_count,
   output int unsigned               result_count,
   output int unsigned               frame_count
);

   import bb3_pkg::*;

   typedef struct packed {
      logic [CH_W-1:0] red;
      logic [CH_W-1:0] green;
      logic [CH_W-1:0] blue;
      logic            frame_end;
   } blur_px_t;

   localparam int LINE_DEPTH = 2 * MAX_WIDTH;

   logic [PIX_W-1:0]  line_mem [LINE_DEPTH];
   logic [PIX_W-1:0]  win_q [6];
   int unsigned       col_q;
   int unsigned       row_q;
   int unsigned       pos_q;
   logic [WCFG_W-1:0] width_r;
   logic [HCFG_W-1:0] height_r;
   blur_px_t          blurred_q [$];

   task automatic clear_stream();
      for (int i = 0; i < 6; i++) win_q[i] = '0;
      col_q = 0;
      row_q = 0;
      pos_q = 0;
   endtask

   task automatic predict_blur(input logic [0:0] op, input logic [7:0] r, g, b);
      int unsigned      w, h, col, q, orow, ocol, cnt, total;
      int unsigned      sum [3];
      logic [PIX_W-1:0] pix;
      logic [PIX_W-1:0] win [9];
      logic [2:0]       ok_col, ok_row;
      bit               last;
      blur_px_t         px;
      w = width_r;
      if (w == 0) w = 1;
      if (w > MAX_WIDTH) w = MAX_WIDTH;
      h = (height_r == 0) ? 1 : height_r;
      col = (col_q >= w) ? 0 : col_q;
      pix = (op == OP_DRAIN) ? '0 : {b, g, r};
      last = 1'b0;

      // read both line stores at this column, then overwrite the older row
      for (int i = 0; i < 6; i++) win[i] = win_q[i];
      win[6] = line_mem[(row_q % 2) * MAX_WIDTH + col];
      win[7] = line_mem[((row_q + 1) % 2) * MAX_WIDTH + col];
      win[8] = pix;
      line_mem[(row_q % 2) * MAX_WIDTH + col] = pix;

      if (pos_q > 0 || row_q * w + col >= w + 1) begin
         q = pos_q;
         orow = q / w;
         ocol = q % w;
         total = w * h;
         ok_col[0] = (ocol > 0);
         ok_col[1] = 1'b1;
         ok_col[2] = (ocol + 1 < w);
         ok_row[0] = (orow > 0);
         ok_row[1] = 1'b1;
         ok_row[2] = (orow + 1 < h);
         for (int ch = 0; ch < 3; ch++) sum[ch] = 0;
         cnt = 0;
         for (int ci = 0; ci < 3; ci++) begin
            for (int ri = 0; ri < 3; ri++) begin
               if (ok_col[ci] && ok_row[ri]) begin
                  for (int ch = 0; ch < 3; ch++) sum[ch] += win[ci * 3 + ri][8 * ch +: 8];
                  cnt++;
               end
            end
         end
         // mean rounded half up
         px.red   = 8'((2 * sum[0] + cnt) / (2 * cnt));
         px.green = 8'((2 * sum[1] + cnt) / (2 * cnt));
         px.blue  = 8'((2 * sum[2] + cnt) / (2 * cnt));
         last = (q + 1 >= total);
         px.frame_end = last;
         blurred_q.push_back(px);
         if (!last) pos_q = q + 1;
      end

      if (last) begin
         clear_stream();
      end else begin
         for (int i = 0; i < 6; i++) win_q[i] = win[i + 3];
         if (col + 1 >= w) begin
            col_q = 0;
            row_q = (row_q + 1) & 32'hFFF;
         end else begin
            col_q = col + 1;
         end
      end
   endtask

   task automatic check_field(input string name, input logic [7:0] exp_v, got_v,
                              inout bit bad);
      if (got_v !== exp_v) begin
         bad = 1'b1;
         if (fail_count < 40)
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, got_v);
      end
   endtask

   task automatic check_blur();
      blur_px_t exp_px;
      bit       bad;
      bad = 1'b0;
      if (blurred_q.size() == 0) begin
         fail_count++;
         $display("%0t: result with no request pending, expected none, got %0d %0d %0d end %0d",
                  $time, rsp_out_red, rsp_out_green, rsp_out_blue, rsp_frame_end);
      end else begin
         exp_px = blurred_q.pop_front();
         check_field("out_red", exp_px.red, rsp_out_red, bad);
         check_field("out_green", exp_px.green, rsp_out_green, bad);
         check_field("out_blue", exp_px.blue, rsp_out_blue, bad);
         check_field("frame_end", {7'd0, exp_px.frame_end}, {7'd0, rsp_frame_end}, bad);
         if (bad) fail_count++;
         result_count++;
         if (exp_px.frame_end) frame_count++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         width_r = 11'd640;
         height_r = 12'd480;
         for (int i = 0; i < LINE_DEPTH; i++) line_mem[i] = '0;
         clear_stream();
         blurred_q.delete();
         fail_count = 0;
         result_count = 0;
         frame_count = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_WIDTH) width_r = csr_wdata[WCFG_W-1:0];
            else if (csr_index == CSR_HEIGHT) height_r = csr_wdata[HCFG_W-1:0];
         end
         if (rsp_valid && !rsp_stall) check_blur();
         if (req_valid && !req_stall) predict_blur(req_operation, req_red, req_green, req_blue);
      end
      expect_count = blurred_q.size();
   end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

   import bb3_pkg::*;

   localparam int RAND_ITEMS  = 1350;
   localparam int QUIET_LIMIT = 4000;
   localparam int SETTLE      = 8;
   localparam int HOLD_CYCLES = 400;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   logic [0:0]       req_operation = OP_PIXEL;
   logic [7:0]       req_red = '0;
   logic [7:0]       req_green = '0;
   logic [7:0]       req_blue = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   logic [7:0]       rsp_out_red;
   logic [7:0]       rsp_out_green;
   logic [7:0]       rsp_out_blue;
   logic             rsp_frame_end;
   logic             csr_valid = 1'b0;
   logic             csr_ready;
   logic [0:0]       csr_index = CSR_WIDTH;
   logic [CSR_W-1:0] csr_wdata = '0;

   int unsigned fail_count, expect_count, result_count, frame_count;
   int          tx_idle_pct = 24;
   int          rx_idle_pct = 63;
   bit          long_hold_req = 1'b0;
   bit          hold_used = 1'b0;
   int          hold_left = 0;
   int          quiet_cycles = 0;
   int unsigned req_count = 0;
   int unsigned ignored_count = 0;
   int unsigned csr_count = 0;

   always #5 clock = ~clock;

   box_blur_3x3_rgb_unit u_top (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_operation (req_operation),
      .req_red       (req_red),
      .req_green     (req_green),
      .req_blue      (req_blue),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_red   (rsp_out_red),
      .rsp_out_green (rsp_out_green),
      .rsp_out_blue  (rsp_out_blue),
      .rsp_frame_end (rsp_frame_end),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   blur_checker u_blur_check (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_operation (req_operation),
      .req_red       (req_red),
      .req_green     (req_green),
      .req_blue      (req_blue),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_red   (rsp_out_red),
      .rsp_out_green (rsp_out_green),
      .rsp_out_blue  (rsp_out_blue),
      .rsp_frame_end (rsp_frame_end),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .fail_count    (fail_count),
      .expect_count  (expect_count),
      .result_count  (result_count),
      .frame_count   (frame_count)
   );

   // ends the run when nothing moves on any channel for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("box_blur_3x3_rgb_unit verification failed");
            $finish;
         end
      end
   end

   // result side: random stall, plus one long hold-off so the pipeline backs up
   always @(negedge clock) begin
      if (long_hold_req && !hold_used) begin
         hold_used = 1'b1;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < rx_idle_pct);
      end
   end

   function automatic logic [7:0] pick_chan();
      case ($urandom_range(0, 7))
         0: return 8'h00;
         1: return 8'hFF;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic send_req(input logic [0:0] op, input logic [7:0] r, g, b);
      while ($urandom_range(0, 99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_operation <= op;
      req_red <= r;
      req_green <= g;
      req_blue <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
      req_count++;
   endtask

   task automatic send_rand(input logic [0:0] op);
      send_req(op, pick_chan(), pick_chan(), pick_chan());
   endtask

   // block is idle once all results are in and the pipeline has emptied
   task automatic settle_results();
      req_valid <= 1'b0;
      while (expect_count != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic write_csr(input logic [0:0] idx, input int unsigned data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data[CSR_W-1:0];
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
      csr_count++;
   endtask

   task automatic set_frame(input int unsigned w, h);
      settle_results();
      write_csr(CSR_WIDTH, w);
      write_csr(CSR_HEIGHT, h);
   endtask

   // raster pixels then width+1 drains; noisy swaps the odd item kind
   task automatic send_frame(input int unsigned w, h, input bit noisy,
                             input int unsigned limit);
      int unsigned sent;
      sent = 0;
      for (int unsigned i = 0; i < w * h && sent < limit; i++) begin
         if (noisy && $urandom_range(0, 19) == 0) send_rand(OP_DRAIN);
         else send_rand(OP_PIXEL);
         sent++;
      end
      for (int unsigned i = 0; i <= w && sent < limit; i++) begin
         if (noisy && $urandom_range(0, 19) == 0) begin
            send_rand(OP_PIXEL);
            ignored_count++;
         end else begin
            send_rand(OP_DRAIN);
         end
         sent++;
      end
   endtask

   // 1x1 frames of drains until a frame end puts the stream back at the origin
   task automatic clear_to_idle();
      int unsigned closed;
      set_frame(1, 1);
      closed = frame_count;
      do begin
         send_rand(OP_DRAIN);
         settle_results();
      end while (frame_count == closed);
   endtask

   initial begin
      int unsigned w, h, k, start;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // widest frame fills both line stores: width clamps to max, height 0 acts as 1
      write_csr(CSR_WIDTH, 12'hFFF);
      write_csr(CSR_HEIGHT, 0);
      send_frame(MAX_WIDTH, 1, 1'b0, 32'hFFFF_FFFF);

      set_frame(1, 3);
      send_frame(1, 3, 1'b0, 32'hFFFF_FFFF);

      // width 0 acts as 1: single pixel, drain data must be dropped
      set_frame(0, 1);
      send_req(OP_PIXEL, 8'hFF, 8'hFF, 8'hFF);
      send_req(OP_DRAIN, 8'hFF, 8'hFF, 8'hFF);
      send_req(OP_DRAIN, 8'hFF, 8'hFF, 8'hFF);

      // corner/edge/center counts, rounding, drain in a pixel slot, pixel in a drain slot
      set_frame(3, 3);
      send_req(OP_PIXEL, 8'hFF, 8'h00, 8'h01);
      send_req(OP_PIXEL, 8'hFF, 8'hFF, 8'h00);
      send_req(OP_PIXEL, 8'h00, 8'hFF, 8'h01);
      send_req(OP_PIXEL, 8'h01, 8'h00, 8'hFF);
      send_req(OP_DRAIN, 8'hFF, 8'hFF, 8'hFF);
      send_req(OP_PIXEL, 8'hFF, 8'h01, 8'hFF);
      send_req(OP_PIXEL, 8'h00, 8'h00, 8'h00);
      send_req(OP_PIXEL, 8'hFF, 8'hFF, 8'hFF);
      send_req(OP_PIXEL, 8'h80, 8'h7F, 8'h01);
      send_req(OP_DRAIN, 8'h00, 8'h00, 8'h00);
      send_req(OP_PIXEL, 8'h12, 8'h34, 8'h56);
      send_req(OP_DRAIN, 8'hAA, 8'h55, 8'hAA);
      send_req(OP_DRAIN, 8'h00, 8'h00, 8'h00);

      // tall frame cut short: shrinking height makes the next output the last
      set_frame(1, 4095);
      repeat (5) send_rand(OP_PIXEL);
      settle_results();
      write_csr(CSR_HEIGHT, 2);
      send_rand(OP_PIXEL);

      start = req_count - ignored_count;
      set_frame(32, 6);
      long_hold_req = 1'b1;
      send_frame(32, 6, 1'b1, 32'hFFFF_FFFF);

      while (req_count - ignored_count - start < RAND_ITEMS) begin
         k = req_count - ignored_count - start;
         if (k >= 2 * RAND_ITEMS / 3) begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
         end else if (k >= RAND_ITEMS / 3) begin
            tx_idle_pct = 63;
            rx_idle_pct = 24;
         end
         case ($urandom_range(0, 9))
            0: w = 1;
            1: w = $urandom_range(33, 64);
            default: w = $urandom_range(2, 12);
         endcase
         case ($urandom_range(0, 7))
            0: h = 1;
            1: h = (w <= 12) ? $urandom_range(9, 24) : $urandom_range(2, 4);
            default: h = $urandom_range(2, 8);
         endcase
         if ($urandom_range(0, 7) == 0) begin
            // broken frame: cut off, registers changed mid-stream, random tail
            set_frame(w, h);
            send_frame(w, h, 1'b1, $urandom_range(1, w * h + w));
            settle_results();
            write_csr(CSR_WIDTH, $urandom_range(1, 16));
            write_csr(CSR_HEIGHT, $urandom_range(1, 16));
            repeat ($urandom_range(0, 24))
               send_rand(($urandom_range(0, 1) == 0) ? OP_PIXEL : OP_DRAIN);
            clear_to_idle();
         end else begin
            set_frame((w == 1 && $urandom_range(0, 1) == 1) ? 0 : w,
                      (h == 1 && $urandom_range(0, 1) == 1) ? 0 : h);
            send_frame(w, h, 1'b1, 32'hFFFF_FFFF);
         end
      end

      settle_results();
      $display("%0d requests (%0d dropped in drain slots), %0d results checked, %0d frames",
               req_count, ignored_count, result_count, frame_count);
      $display("%0d register writes; sizes 1x1 to 1024 wide, mid-frame changes, three idle mixes",
               csr_count);
      if (fail_count == 0 && expect_count == 0) begin
         $display("box_blur_3x3_rgb_unit verification clean");
      end else begin
         $display("box_blur_3x3_rgb_unit verification failed");
      end
      $finish;
   end

endmodule
